[rtl/tdpt_pkg.sv]
// Shared types and constants for the trial-division prime test unit.
// Used by tdpt_ctrl, tdpt_dpath and trial_division_prime_test_unit.
`default_nettype none

package tdpt_pkg;

    // Width of the candidate port and of the operand that is tested.
    localparam int CAND_WIDTH  = 32;
    localparam int VALUE_WIDTH = 32;

    // The divisor never exceeds sqrt(2^(VALUE_WIDTH-1)) + 1.
    localparam int DIV_WIDTH = VALUE_WIDTH / 2 + 1;
    localparam int SQ_WIDTH  = 2 * DIV_WIDTH;
    localparam int CNT_WIDTH = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    // Controller states, one-hot.
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SQUARE = 7'b0000010,
        S_BOUND  = 7'b0000100,
        S_DIVIDE = 7'b0001000,
        S_TEST   = 7'b0010000,
        S_FINISH = 7'b0100000,
        S_HOLD   = 7'b1000000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the operand, divisor back to two
        logic square;      // register divisor squared
        logic start_div;   // clear remainder, load bit counter
        logic div_step;    // one restoring remainder step
        logic next_div;    // advance to the next divisor
        logic set_verdict; // write the verdict register
        logic verdict;     // value for the verdict register
        logic publish;     // copy the verdict into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic trivial;   // negative, zero or one: not prime
        logic sq_over;   // divisor squared exceeds the operand
        logic div_last;  // last remainder step is under way
        logic rem_zero;  // remainder of the finished division is zero
    } stat_t;

endpackage

`default_nettype wire

[rtl/tdpt_dpath.sv]
// Datapath of the prime test: operand, divisor, square and an iterative
// one-bit-per-cycle remainder unit. Depends on tdpt_pkg.
`default_nettype none

module tdpt_dpath (
    input  wire logic                             aclk,
    input  wire logic [tdpt_pkg::CAND_WIDTH-1:0]  candidate,
    input  wire tdpt_pkg::cmd_t                   cmd,
    output tdpt_pkg::stat_t                       stat,
    output logic                                  is_prime
);
    import tdpt_pkg::*;

    logic [VALUE_WIDTH-1:0] val_reg;
    logic [DIV_WIDTH-1:0]   div_reg;
    logic [SQ_WIDTH-1:0]    sq_reg;
    logic [DIV_WIDTH-1:0]   rem_reg,  rem_next;
    logic [CNT_WIDTH-1:0]   cnt_reg;
    logic                   verdict_reg;
    logic                   out_reg;
    logic [DIV_WIDTH:0]     partial;

    // One restoring step: shift in the next operand bit, subtract if it fits.
    always_comb begin
        partial = {rem_reg, val_reg[cnt_reg]};
        if (partial >= {1'b0, div_reg}) begin
            rem_next = DIV_WIDTH'(partial - {1'b0, div_reg});
        end else begin
            rem_next = partial[DIV_WIDTH-1:0];
        end
    end

    // Datapath registers, all loaded under command.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            val_reg <= VALUE_WIDTH'($unsigned(candidate));
            div_reg <= DIV_WIDTH'(2);
        end
        if (cmd.next_div) begin
            div_reg <= div_reg + DIV_WIDTH'(1);
        end
        if (cmd.square) begin
            sq_reg <= SQ_WIDTH'(div_reg) * SQ_WIDTH'(div_reg);
        end
        if (cmd.start_div) begin
            rem_reg <= '0;
            cnt_reg <= CNT_WIDTH'(VALUE_WIDTH - 1);
        end
        if (cmd.div_step) begin
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - CNT_WIDTH'(1);
        end
        if (cmd.set_verdict) begin
            verdict_reg <= cmd.verdict;
        end
        if (cmd.publish) begin
            out_reg <= verdict_reg;
        end
    end

    // Status toward the controller.
    always_comb begin
        stat.trivial  = val_reg[VALUE_WIDTH-1] || (val_reg < VALUE_WIDTH'(2));
        stat.sq_over  = sq_reg > SQ_WIDTH'(val_reg);
        stat.div_last = (cnt_reg == '0);
        stat.rem_zero = (rem_reg == '0);
    end

    assign is_prime = out_reg;

endmodule

`default_nettype wire

[rtl/tdpt_ctrl.sv]
// Controller of the prime test: sequences square, bound check and remainder
// steps for each divisor and owns the handshakes. Depends on tdpt_pkg.
`default_nettype none

module tdpt_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  wire tdpt_pkg::stat_t  stat,
    output tdpt_pkg::cmd_t        cmd
);
    import tdpt_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg) inside
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE: begin
                cmd.square = 1'b1;
                if (stat.trivial) begin
                    cmd.set_verdict = 1'b1;
                    cmd.verdict     = 1'b0;
                    state_next      = S_FINISH;
                end else begin
                    state_next = S_BOUND;
                end
            end
            S_BOUND: begin
                if (stat.sq_over) begin
                    cmd.set_verdict = 1'b1;
                    cmd.verdict     = 1'b1;
                    state_next      = S_FINISH;
                end else begin
                    cmd.start_div = 1'b1;
                    state_next    = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = S_TEST;
                end
            end
            S_TEST: begin
                if (stat.rem_zero) begin
                    cmd.set_verdict = 1'b1;
                    cmd.verdict     = 1'b0;
                    state_next      = S_FINISH;
                end else begin
                    cmd.next_div = 1'b1;
                    state_next   = S_SQUARE;
                end
            end
            S_FINISH, S_HOLD: begin
                // Wait until the output register is free.
                if (!out_valid_reg || m_ready) begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end else begin
                    state_next = S_HOLD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output word valid: set on publish, cleared when taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.publish) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;

    // A new word never overwrites one that is still waiting.
    a_publish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> (!out_valid_reg || m_ready))
        else $error("result published over a pending word");

    // Prime is declared only once the square bound is passed.
    a_prime_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.set_verdict && cmd.verdict) |-> (state_reg == S_BOUND && stat.sq_over))
        else $error("prime verdict without bound check");

    // The last remainder step always leads to the zero test.
    a_div_to_test: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIVIDE && stat.div_last) |=> (state_reg == S_TEST))
        else $error("division did not end in test");

    // Leaving the remainder test toward finish requires a zero remainder.
    a_composite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TEST && cmd.set_verdict) |-> (stat.rem_zero && !cmd.verdict))
        else $error("composite verdict without zero remainder");

endmodule

`default_nettype wire

[rtl/trial_division_prime_test_unit.sv]
// Top level of the trial-division prime test unit.
// Joins tdpt_ctrl and tdpt_dpath; depends on tdpt_pkg.
//
//  Channel   Ports                              Word
//  --------  ---------------------------------  ---------------------------
//  input     s_valid, s_ready, s_candidate      32-bit signed candidate
//  result    m_valid, m_ready, m_is_prime       1 if the candidate is prime
//
// Run time: negatives, zero and one are settled in the square state plus the
// handoff; otherwise each divisor tried passes square, bound check, one
// remainder bit per cycle and zero test, and a prime ends with a final square
// and bound check and the handoff. The iterative remainder unit dominates the
// run time. One item is in work at a time.
// Reset is synchronous and active low; it clears the controller and the
// output valid. A stalled result waits in the output register while the
// next word is accepted and tested.
`default_nettype none

module trial_division_prime_test_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [tdpt_pkg::CAND_WIDTH-1:0]  s_candidate,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_is_prime
);
    import tdpt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencer and handshakes.
    tdpt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Operand, divisor and remainder arithmetic.
    tdpt_dpath u_dpath (
        .aclk      (aclk),
        .candidate (s_candidate),
        .cmd       (cmd),
        .stat      (stat),
        .is_prime  (m_is_prime)
    );

endmodule

`default_nettype wire
